// ----- rtl/lcl_pkg.sv -----
`default_nettype none

package lcl_pkg;

  // widths and limits
  localparam int POS_BITS  = 16;
  localparam int ARG_SLOTS = 16;
  localparam int MAX_RES   = 3;
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);
  localparam logic [3:0] ARG_LIMIT = (ARG_SLOTS - 1 > 15) ? 4'd15 : 4'(ARG_SLOTS - 1);

  // characters
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LBR    = 8'h5B;
  localparam logic [7:0] CH_RBR    = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_GFIRST = 8'h21;
  localparam logic [7:0] CH_GLAST  = 8'h7E;

  // token codes
  localparam logic [3:0] TK_OPEN    = 4'd0;
  localparam logic [3:0] TK_CLOSE   = 4'd1;
  localparam logic [3:0] TK_COLON   = 4'd2;
  localparam logic [3:0] TK_EQUAL   = 4'd3;
  localparam logic [3:0] TK_EOL     = 4'd4;
  localparam logic [3:0] TK_COMMENT = 4'd5;
  localparam logic [3:0] TK_QUOTED  = 4'd6;
  localparam logic [3:0] TK_STRING  = 4'd7;
  localparam logic [3:0] TK_UNKNOWN = 4'd8;

  // lexer modes
  localparam logic [1:0] LX_WAIT    = 2'd0;
  localparam logic [1:0] LX_QUOTED  = 2'd1;
  localparam logic [1:0] LX_STRING  = 2'd2;
  localparam logic [1:0] LX_COMMENT = 2'd3;

  // line states
  localparam logic [2:0] LN_START    = 3'd0;
  localparam logic [2:0] LN_SEC_BEG  = 3'd1;
  localparam logic [2:0] LN_SEC_NAME = 3'd2;
  localparam logic [2:0] LN_SEC_END  = 3'd3;
  localparam logic [2:0] LN_DIR_BEG  = 3'd4;
  localparam logic [2:0] LN_DIR_ARG  = 3'd5;

  // line kinds
  localparam logic [2:0] LK_UNKNOWN   = 3'd0;
  localparam logic [2:0] LK_COMMENT   = 3'd1;
  localparam logic [2:0] LK_SECTION   = 3'd2;
  localparam logic [2:0] LK_DIRECTIVE = 3'd3;

  // separators
  localparam logic [1:0] SEP_NONE  = 2'd0;
  localparam logic [1:0] SEP_COLON = 2'd1;
  localparam logic [1:0] SEP_EQUAL = 2'd2;

  // result kinds
  localparam logic RK_TOKEN = 1'b0;
  localparam logic RK_LINE  = 1'b1;

  typedef struct packed {
    logic       rkind;
    logic [3:0] ttype;
    logic [15:0] sbeg;
    logic [15:0] send;
    logic       kept;
    logic [2:0] lkind;
    logic [1:0] sep;
    logic [3:0] args;
  } result_t;

  // all results of one character, in order
  typedef struct packed {
    result_t [MAX_RES-1:0] res;
    logic [1:0]            cnt;
  } bundle_t;

  typedef struct packed {
    logic [2:0] lmode;
    logic [1:0] sep;
    logic [3:0] args;
  } cls_t;

  typedef struct packed {
    cls_t    cls;
    bundle_t bun;
  } step_t;

  typedef struct packed {
    logic [1:0]          mode;
    logic                esc;
    logic [POS_BITS-1:0] pbeg;
    logic                tvalid;
    logic [3:0]          ttype;
  } lex_t;

endpackage

`default_nettype wire

// ----- rtl/lcl_front.sv -----
`default_nettype none

module lcl_front
  import lcl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    s_tvalid,
  output logic         s_tready,
  input  wire logic [7:0] s_tdata,  // char_byte
  input  wire logic    s_tlast,     // end_of_text
  input  wire logic    q_ready,
  output logic         q_push,
  output bundle_t      q_bundle
);

  function automatic logic is_graphic(logic [7:0] c);
    return (c >= CH_GFIRST) && (c <= CH_GLAST);
  endfunction

  function automatic bundle_t put(bundle_t b, result_t t);
    bundle_t r;
    r = b;
    if (r.cnt < 2'(MAX_RES)) begin
      r.res[r.cnt] = t;
      r.cnt = r.cnt + 2'd1;
    end
    return r;
  endfunction

  function automatic step_t finish(step_t s, logic [2:0] kind, logic [15:0] e);
    step_t r;
    logic [2:0] k;
    result_t t;
    r = s;
    k = kind;
    if (kind == LK_DIRECTIVE && r.cls.sep != SEP_NONE) begin
      k = LK_DIRECTIVE + {1'b0, r.cls.sep};
    end
    t.rkind = RK_LINE;
    t.ttype = TK_OPEN;
    t.sbeg  = '0;
    t.send  = e;
    t.kept  = 1'b0;
    t.lkind = k;
    t.sep   = r.cls.sep;
    t.args  = r.cls.args;
    r.bun = put(r.bun, t);
    r.cls.lmode = LN_START;
    r.cls.sep   = SEP_NONE;
    r.cls.args  = '0;
    return r;
  endfunction

  function automatic step_t feed(step_t s, logic [3:0] tt, logic [15:0] b, logic [15:0] e);
    step_t r;
    logic kept;
    logic fin;
    logic str;
    logic ends;
    logic [2:0] kind;
    result_t t;
    r = s;
    kept = 1'b0;
    fin  = 1'b0;
    kind = LK_UNKNOWN;
    str  = (tt == TK_STRING) || (tt == TK_QUOTED);
    ends = (tt == TK_COMMENT) || (tt == TK_EOL);
    case (r.cls.lmode)
      LN_START: begin
        if (tt == TK_COMMENT) begin
          fin = 1'b1;
          kind = LK_COMMENT;
        end else if (tt == TK_OPEN) begin
          r.cls.lmode = LN_SEC_BEG;
        end else if (str) begin
          kept = 1'b1;
          r.cls.lmode = LN_DIR_BEG;
        end
      end
      LN_SEC_BEG: begin
        if (tt == TK_CLOSE) begin
          r.cls.lmode = LN_SEC_END;
        end else if (str) begin
          kept = 1'b1;
          r.cls.lmode = LN_SEC_NAME;
        end
      end
      LN_SEC_NAME: begin
        if (tt == TK_CLOSE) r.cls.lmode = LN_SEC_END;
      end
      LN_SEC_END: begin
        if (ends) begin
          fin = 1'b1;
          kind = LK_SECTION;
        end
      end
      LN_DIR_BEG: begin
        if (tt == TK_COLON) begin
          r.cls.sep = SEP_COLON;
          r.cls.lmode = LN_DIR_ARG;
        end else if (tt == TK_EQUAL) begin
          r.cls.sep = SEP_EQUAL;
          r.cls.lmode = LN_DIR_ARG;
        end else if (str) begin
          kept = 1'b1;
          r.cls.lmode = LN_DIR_ARG;
        end else if (ends) begin
          fin = 1'b1;
          kind = LK_DIRECTIVE;
        end
      end
      LN_DIR_ARG: begin
        if (str) begin
          kept = 1'b1;
        end else if (ends) begin
          fin = 1'b1;
          kind = LK_DIRECTIVE;
        end
      end
      default: begin
        r.cls.lmode = LN_START;
      end
    endcase
    if (kept) begin
      if (r.cls.args < ARG_LIMIT) r.cls.args = r.cls.args + 4'd1;
      else kept = 1'b0;
    end
    t.rkind = RK_TOKEN;
    t.ttype = tt;
    t.sbeg  = b;
    t.send  = e;
    t.kept  = kept;
    t.lkind = LK_UNKNOWN;
    t.sep   = SEP_NONE;
    t.args  = '0;
    r.bun = put(r.bun, t);
    if (fin) r = finish(r, kind, e);
    return r;
  endfunction

  // handling of a character in waiting mode
  function automatic lex_t lexdef(logic [7:0] c, logic [15:0] p, logic [15:0] np,
                                  logic [15:0] pb);
    lex_t l;
    l.mode   = LX_WAIT;
    l.esc    = 1'b0;
    l.pbeg   = pb;
    l.tvalid = 1'b1;
    l.ttype  = TK_UNKNOWN;
    if (c == CH_SPACE || c == CH_TAB) begin
      l.tvalid = 1'b0;
    end else if (c == CH_LBR) begin
      l.ttype = TK_OPEN;
    end else if (c == CH_RBR) begin
      l.ttype = TK_CLOSE;
    end else if (c == CH_COLON) begin
      l.ttype = TK_COLON;
    end else if (c == CH_EQUAL) begin
      l.ttype = TK_EQUAL;
    end else if (c == CH_CR || c == CH_LF) begin
      l.ttype = TK_EOL;
    end else if (c == CH_HASH) begin
      l.tvalid = 1'b0;
      l.pbeg = np;
      l.mode = LX_COMMENT;
    end else if (c == CH_QUOTE) begin
      l.tvalid = 1'b0;
      l.pbeg = np;
      l.mode = LX_QUOTED;
    end else if (c == CH_BSLASH) begin
      l.tvalid = 1'b0;
      l.pbeg = p;
      l.mode = LX_STRING;
      l.esc = 1'b1;
    end else if (is_graphic(c)) begin
      l.tvalid = 1'b0;
      l.pbeg = p;
      l.mode = LX_STRING;
    end
    return l;
  endfunction

  logic [1:0]          lmode, lmode_next;
  logic                esc, esc_next;
  logic [POS_BITS-1:0] pbeg, pbeg_next;
  logic [POS_BITS-1:0] pos, pos_next;
  cls_t                cls;
  cls_t                cls_next;
  step_t               st;
  logic                accept;

  assign s_tready = q_ready;
  assign accept   = s_tvalid && q_ready;

  always_comb begin
    logic [15:0] p;
    logic [15:0] np;
    logic delim;
    lex_t l;
    p  = 16'(pos);
    np = 16'(pos + 1'b1);
    delim = (s_tdata == CH_QUOTE) || (s_tdata == CH_HASH) || (s_tdata == CH_LBR) ||
            (s_tdata == CH_RBR) || (s_tdata == CH_COLON) || (s_tdata == CH_EQUAL);
    st.cls = cls;
    st.bun = '0;
    lmode_next = lmode;
    esc_next   = esc;
    pbeg_next  = pbeg;
    l = lexdef(s_tdata, p, np, pbeg);
    case (lmode)
      LX_QUOTED: begin
        if (s_tdata == CH_QUOTE && !esc) begin
          st = feed(st, TK_QUOTED, pbeg, p);
          lmode_next = LX_WAIT;
          esc_next = 1'b0;
        end else if (s_tdata == CH_BSLASH) begin
          esc_next = ~esc;
        end else if (s_tdata == CH_SPACE || s_tdata == CH_TAB || is_graphic(s_tdata)) begin
          esc_next = 1'b0;
        end else begin
          st = feed(st, TK_UNKNOWN, pbeg, np);
          lmode_next = LX_WAIT;
          esc_next = 1'b0;
        end
      end
      LX_STRING: begin
        if (delim && esc) begin
          esc_next = 1'b0;
        end else if (s_tdata == CH_BSLASH) begin
          esc_next = ~esc;
        end else if (is_graphic(s_tdata) && !delim) begin
          esc_next = 1'b0;
        end else begin
          // string ends, the byte is handled again in waiting mode
          st = feed(st, TK_STRING, pbeg, p);
          lmode_next = l.mode;
          esc_next = l.esc;
          pbeg_next = l.pbeg;
          if (l.tvalid) st = feed(st, l.ttype, p, np);
        end
      end
      LX_COMMENT: begin
        if (s_tdata == CH_CR || s_tdata == CH_LF) begin
          st = feed(st, TK_COMMENT, pbeg, p);
          lmode_next = l.mode;
          esc_next = l.esc;
          pbeg_next = l.pbeg;
          if (l.tvalid) st = feed(st, l.ttype, p, np);
        end
      end
      default: begin
        lmode_next = l.mode;
        esc_next = l.esc;
        pbeg_next = l.pbeg;
        if (l.tvalid) st = feed(st, l.ttype, p, np);
      end
    endcase
    pos_next = POS_BITS'(pos + 1'b1);
    cls_next = st.cls;
    if (s_tlast) begin
      // flush pending token and open line, then back to reset
      case (lmode_next)
        LX_QUOTED:  st = feed(st, TK_QUOTED, pbeg_next, np);
        LX_STRING:  st = feed(st, TK_STRING, pbeg_next, np);
        LX_COMMENT: st = feed(st, TK_COMMENT, pbeg_next, np);
        default: ;
      endcase
      if (st.cls.lmode == LN_SEC_END) begin
        st = finish(st, LK_SECTION, np);
      end else if (st.cls.lmode == LN_DIR_BEG || st.cls.lmode == LN_DIR_ARG) begin
        st = finish(st, LK_DIRECTIVE, np);
      end else if (st.cls.lmode != LN_START) begin
        st = finish(st, LK_UNKNOWN, np);
      end
      lmode_next = LX_WAIT;
      esc_next   = 1'b0;
      pbeg_next  = '0;
      pos_next   = '0;
      cls_next   = '0;
    end
  end

  assign q_push   = accept && (st.bun.cnt != 2'd0);
  assign q_bundle = st.bun;

  always_ff @(posedge clk) begin
    if (rst) begin
      lmode <= LX_WAIT;
      esc   <= 1'b0;
      pbeg  <= '0;
      pos   <= '0;
      cls   <= '0;
    end else if (accept) begin
      lmode <= lmode_next;
      esc   <= esc_next;
      pbeg  <= pbeg_next;
      pos   <= pos_next;
      cls   <= cls_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lcl_queue.sv -----
`default_nettype none

module lcl_queue
  import lcl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  bundle_t   push_bundle,
  output logic      push_ready,
  output logic      head_valid,
  output bundle_t   head,
  input  wire logic pop
);

  bundle_t              mem [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (count != QCNT_BITS'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_bundle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_BITS'(QDEPTH)) else $error("queue count above depth");

  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    QPTR_BITS'(wr_ptr - rd_ptr) == QPTR_BITS'(count)) else $error("queue pointers off");

  a_no_empty_push: assert property (@(posedge clk) disable iff (rst)
    push |-> push_bundle.cnt != 2'd0) else $error("empty bundle pushed");

  a_head_nonempty: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> head.cnt != 2'd0) else $error("queued bundle without results");

endmodule

`default_nettype wire

// ----- rtl/lcl_back.sv -----
`default_nettype none

module lcl_back
  import lcl_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   head_valid,
  input  bundle_t     head,
  output logic        pop,
  output logic        m_tvalid,
  input  wire logic   m_tready,
  output logic [47:0] m_tdata,  // token_type, span_begin, span_end, kept_as_argument,
                                // line_kind, separator_seen, argument_total, zero pad
  output logic        m_tuser,  // result_kind
  output logic        m_tlast   // final_result
);

  logic [1:0] idx;
  logic       load;
  logic       last_now;
  result_t    res;

  assign load     = !m_tvalid || m_tready;
  assign last_now = (idx == head.cnt - 2'd1);
  assign pop      = head_valid && load && last_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else if (load) begin
      m_tvalid <= head_valid;
      if (head_valid) idx <= last_now ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      res     <= head.res[idx];
      m_tlast <= last_now;
    end
  end

  assign m_tuser = res.rkind;
  assign m_tdata = {2'b00, res.args, res.sep, res.lkind, res.kept,
                    res.send, res.sbeg, res.ttype};

endmodule

`default_nettype wire

// ----- rtl/config_text_lexer_line_classifier_core.sv -----
`default_nettype none

// Lexer and line classifier for INI-like configuration text. One character
// enters per beat on the s_ side (tlast marks the final character of the
// text); each character yields zero to three result beats on the m_ side:
// tokens (brackets, colon, equal, eol, comment, quoted, string, unknown)
// and, when a line finishes, one line summary (m_tuser high). m_tlast marks
// the last result beat caused by one character. The front takes one
// character per cycle while the queue has room and works out all of its
// results in that cycle; they go as one bundle into a 4-entry queue. The
// back sends one result beat per cycle from an output register while
// m_tready is high. So, with the receiver ready, input runs at one
// character per cycle as long as the characters average no more than one
// result each; a character with k results takes k output beats, and the
// front stalls only once the queue holds 4 pending bundles. A result beat
// passes the queue and then the output register. No clearing pass after reset.
module config_text_lexer_line_classifier_core
  import lcl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // character input
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // char_byte
  input  wire logic        s_tlast,   // end_of_text
  // result output
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // token_type[3:0], span_begin[19:4], span_end[35:20],
                                      // kept_as_argument[36], line_kind[39:37],
                                      // separator_seen[41:40], argument_total[45:42], pad
  output logic             m_tuser,   // result_kind
  output logic             m_tlast    // final_result
);

  // front to queue
  logic    q_push;
  logic    q_ready;
  bundle_t q_bundle;

  // queue to back
  logic    head_valid;
  bundle_t head;
  logic    pop;

  // lexer, position counter and line classifier
  lcl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_bundle (q_bundle)
  );

  // per-character result bundles, decouples the two sides
  lcl_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (q_push),
    .push_bundle (q_bundle),
    .push_ready  (q_ready),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop)
  );

  // serializes each bundle into result beats
  lcl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire

// ----- sim/lexer_result_monitor.sv -----
module lexer_result_monitor
  import lcl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  output int          failures,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // token type field carried by line summaries
  localparam logic [3:0] NO_TOKEN = 4'd0;

  typedef struct packed {
    logic        rkind;
    logic [3:0]  ttype;
    logic [15:0] span_beg;
    logic [15:0] span_end;
    logic        kept;
    logic [2:0]  lkind;
    logic [1:0]  sep;
    logic [3:0]  args;
    logic        last_of_char;
  } lex_result_t;

  // predicted lexer and classifier state
  logic [1:0]  lx_mode;
  logic        lx_esc;
  logic [15:0] lx_pbeg;
  logic [15:0] lx_pos;
  logic [2:0]  ln_mode;
  logic [1:0]  ln_sep;
  logic [3:0]  ln_args;

  lex_result_t char_results[$];
  lex_result_t expected_results[$];
  lex_result_t got, want;

  function automatic string describe(lex_result_t r);
    return $sformatf("kind %0d type %0d span %0d-%0d kept %0d line %0d sep %0d args %0d last %0d",
                     r.rkind, r.ttype, r.span_beg, r.span_end, r.kept, r.lkind, r.sep, r.args,
                     r.last_of_char);
  endfunction

  function automatic void clear_state();
    lx_mode = LX_WAIT;
    lx_esc  = 1'b0;
    lx_pbeg = '0;
    lx_pos  = '0;
    ln_mode = LN_START;
    ln_sep  = SEP_NONE;
    ln_args = '0;
  endfunction

  function automatic void add_result(logic rk, logic [3:0] tt, logic [15:0] b, logic [15:0] e,
                                     logic kept, logic [2:0] lk, logic [1:0] sp,
                                     logic [3:0] cnt);
    lex_result_t r;
    if (char_results.size() >= MAX_RES) return;
    r.rkind = rk;
    r.ttype = tt;
    r.span_beg = b;
    r.span_end = e;
    r.kept = kept;
    r.lkind = lk;
    r.sep = sp;
    r.args = cnt;
    r.last_of_char = 1'b0;
    char_results.push_back(r);
  endfunction

  function automatic void close_line(logic [2:0] lk, logic [15:0] e);
    logic [2:0] k;
    k = lk;
    // a directive with a separator becomes directive colon or directive equal
    if (k == LK_DIRECTIVE && ln_sep != SEP_NONE) k = LK_DIRECTIVE + 3'(ln_sep);
    add_result(RK_LINE, NO_TOKEN, 16'd0, e, 1'b0, k, ln_sep, ln_args);
    ln_mode = LN_START;
    ln_sep  = SEP_NONE;
    ln_args = '0;
  endfunction

  function automatic void take_token(logic [3:0] tt, logic [15:0] b, logic [15:0] e);
    logic       kept, fin, is_str, closes;
    logic [2:0] lk;
    kept   = 1'b0;
    fin    = 1'b0;
    lk     = LK_UNKNOWN;
    is_str = (tt == TK_STRING || tt == TK_QUOTED);
    closes = (tt == TK_COMMENT || tt == TK_EOL);
    case (ln_mode)
      LN_START: begin
        if (tt == TK_COMMENT) begin
          fin = 1'b1;
          lk  = LK_COMMENT;
        end else if (tt == TK_OPEN) begin
          ln_mode = LN_SEC_BEG;
        end else if (is_str) begin
          kept    = 1'b1;
          ln_mode = LN_DIR_BEG;
        end
      end
      LN_SEC_BEG: begin
        if (tt == TK_CLOSE) begin
          ln_mode = LN_SEC_END;
        end else if (is_str) begin
          kept    = 1'b1;
          ln_mode = LN_SEC_NAME;
        end
      end
      LN_SEC_NAME: begin
        if (tt == TK_CLOSE) ln_mode = LN_SEC_END;
      end
      LN_SEC_END: begin
        if (closes) begin
          fin = 1'b1;
          lk  = LK_SECTION;
        end
      end
      LN_DIR_BEG: begin
        if (tt == TK_COLON) begin
          ln_sep  = SEP_COLON;
          ln_mode = LN_DIR_ARG;
        end else if (tt == TK_EQUAL) begin
          ln_sep  = SEP_EQUAL;
          ln_mode = LN_DIR_ARG;
        end else if (is_str) begin
          kept    = 1'b1;
          ln_mode = LN_DIR_ARG;
        end else if (closes) begin
          fin = 1'b1;
          lk  = LK_DIRECTIVE;
        end
      end
      LN_DIR_ARG: begin
        if (is_str) begin
          kept = 1'b1;
        end else if (closes) begin
          fin = 1'b1;
          lk  = LK_DIRECTIVE;
        end
      end
      default: ln_mode = LN_START;
    endcase
    // arguments past the limit are dropped
    if (kept) begin
      if (ln_args < ARG_LIMIT) ln_args = ln_args + 4'd1;
      else kept = 1'b0;
    end
    add_result(RK_TOKEN, tt, b, e, kept, LK_UNKNOWN, SEP_NONE, 4'd0);
    if (fin) close_line(lk, e);
  endfunction

  function automatic logic graphic(logic [7:0] c);
    return c >= CH_GFIRST && c <= CH_GLAST;
  endfunction

  function automatic void lex_wait(logic [7:0] c, logic [15:0] p, logic [15:0] np);
    lx_mode = LX_WAIT;
    lx_esc  = 1'b0;
    if (c == CH_SPACE || c == CH_TAB) return;
    if (c == CH_LBR) take_token(TK_OPEN, p, np);
    else if (c == CH_RBR) take_token(TK_CLOSE, p, np);
    else if (c == CH_COLON) take_token(TK_COLON, p, np);
    else if (c == CH_EQUAL) take_token(TK_EQUAL, p, np);
    else if (c == CH_CR || c == CH_LF) take_token(TK_EOL, p, np);
    else if (c == CH_HASH) begin
      lx_pbeg = np;
      lx_mode = LX_COMMENT;
    end else if (c == CH_QUOTE) begin
      lx_pbeg = np;
      lx_mode = LX_QUOTED;
    end else if (c == CH_BSLASH) begin
      lx_pbeg = p;
      lx_mode = LX_STRING;
      lx_esc  = 1'b1;
    end else if (graphic(c)) begin
      lx_pbeg = p;
      lx_mode = LX_STRING;
    end else begin
      take_token(TK_UNKNOWN, p, np);
    end
  endfunction

  function automatic void predict_char(logic [7:0] c, logic eot);
    logic [15:0] p, np;
    logic [2:0]  lk;
    char_results.delete();
    p  = lx_pos;
    np = p + 16'd1;
    case (lx_mode)
      LX_QUOTED: begin
        if (c == CH_QUOTE && !lx_esc) begin
          // closing quote is consumed
          take_token(TK_QUOTED, lx_pbeg, p);
          lx_mode = LX_WAIT;
          lx_esc  = 1'b0;
        end else if (c == CH_BSLASH) begin
          lx_esc = ~lx_esc;
        end else if (c == CH_SPACE || c == CH_TAB || graphic(c)) begin
          lx_esc = 1'b0;
        end else begin
          // broken quoted string, span reaches past the bad byte
          take_token(TK_UNKNOWN, lx_pbeg, np);
          lx_mode = LX_WAIT;
          lx_esc  = 1'b0;
        end
      end
      LX_STRING: begin
        if (c == CH_QUOTE || c == CH_HASH || c == CH_LBR || c == CH_RBR ||
            c == CH_COLON || c == CH_EQUAL) begin
          if (lx_esc) begin
            lx_esc = 1'b0;
          end else begin
            take_token(TK_STRING, lx_pbeg, p);
            lex_wait(c, p, np);
          end
        end else if (c == CH_BSLASH) begin
          lx_esc = ~lx_esc;
        end else if (graphic(c)) begin
          lx_esc = 1'b0;
        end else begin
          take_token(TK_STRING, lx_pbeg, p);
          lex_wait(c, p, np);
        end
      end
      LX_COMMENT: begin
        if (c == CH_CR || c == CH_LF) begin
          take_token(TK_COMMENT, lx_pbeg, p);
          lex_wait(c, p, np);
        end
      end
      default: lex_wait(c, p, np);
    endcase

    if (eot) begin
      // flush the pending token, finish the open line, start over at offset zero
      if (lx_mode == LX_QUOTED) take_token(TK_QUOTED, lx_pbeg, np);
      else if (lx_mode == LX_STRING) take_token(TK_STRING, lx_pbeg, np);
      else if (lx_mode == LX_COMMENT) take_token(TK_COMMENT, lx_pbeg, np);
      if (ln_mode != LN_START) begin
        if (ln_mode == LN_SEC_END) lk = LK_SECTION;
        else if (ln_mode == LN_DIR_BEG || ln_mode == LN_DIR_ARG) lk = LK_DIRECTIVE;
        else lk = LK_UNKNOWN;
        close_line(lk, np);
      end
      clear_state();
    end else begin
      lx_pos = np;
    end

    if (char_results.size() > 0) char_results[char_results.size() - 1].last_of_char = 1'b1;
    foreach (char_results[i]) expected_results.push_back(char_results[i]);
  endfunction

  initial begin
    failures = 0;
    pending  = 0;
    clear_state();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      expected_results.delete();
    end else begin
      // results first: a character accepted at this edge cannot answer at the same edge
      if (m_tvalid && m_tready) begin
        got.rkind        = m_tuser;
        got.ttype        = m_tdata[3:0];
        got.span_beg     = m_tdata[19:4];
        got.span_end     = m_tdata[35:20];
        got.kept         = m_tdata[36];
        got.lkind        = m_tdata[39:37];
        got.sep          = m_tdata[41:40];
        got.args         = m_tdata[45:42];
        got.last_of_char = m_tlast;
        if (expected_results.size() == 0) begin
          failures++;
          if (failures <= 10) $display("%0t: unexpected result beat: %s", $time, describe(got));
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            failures++;
            if (failures <= 10)
              $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                       $time, describe(want), describe(got));
          end
        end
      end
      if (s_tvalid && s_tready) predict_char(s_tdata, s_tlast);
    end
    pending = expected_results.size();
  end

endmodule

// ----- sim/testbench.sv -----
module testbench;
  import lcl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles without any accepted beat before the run is declared hung
  localparam int STALL_LIMIT = 4000;
  // length of the deliberate receiver hold-off
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_CHARS = 220;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [47:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int failures;
  int pending;
  int burst_left = 0;   // beats left in the current sender burst
  int chars_sent = 0;
  int idle_cycles = 0;
  bit hold_req = 1'b0;  // asks the receiver for one long hold-off

  always #5 clk = ~clk;

  config_text_lexer_line_classifier_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  lexer_result_monitor monitor (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .failures (failures),
    .pending  (pending)
  );

  // offer one character beat and wait for it to be taken; a random gap
  // opens whenever the current burst runs out
  task automatic send_char(input logic [7:0] c, input logic eot);
    int gap;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= eot;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    chars_sent++;
  endtask

  // end of text goes on the last character only when asked
  task automatic send_text(input string s, input bit eot_last);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], eot_last && (i == s.len() - 1));
  endtask

  // bare word: graphic non-delimiters, now and then a backslash escape of any graphic character
  function automatic void add_word(ref logic [7:0] text[$]);
    int n, i;
    logic [7:0] c;
    n = $urandom_range(1, 5);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        text.push_back(CH_BSLASH);
        text.push_back(8'($urandom_range(CH_GFIRST, CH_GLAST)));
      end else begin
        do c = 8'($urandom_range(CH_GFIRST, CH_GLAST));
        while (c == CH_QUOTE || c == CH_HASH || c == CH_LBR || c == CH_RBR ||
               c == CH_COLON || c == CH_EQUAL || c == CH_BSLASH);
        text.push_back(c);
      end
    end
  endfunction

  // quoted string with escapes and blanks, sometimes left open
  function automatic void add_quoted(ref logic [7:0] text[$]);
    int n, i, pick;
    logic [7:0] c;
    text.push_back(CH_QUOTE);
    n = $urandom_range(0, 6);
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        text.push_back(CH_BSLASH);
        text.push_back($urandom_range(0, 1) ? CH_QUOTE : CH_BSLASH);
      end else if (pick == 1) begin
        text.push_back(CH_TAB);
      end else begin
        do c = 8'($urandom_range(CH_SPACE, CH_GLAST));
        while (c == CH_QUOTE || c == CH_BSLASH);
        text.push_back(c);
      end
    end
    if ($urandom_range(0, 9) != 0) text.push_back(CH_QUOTE);
  endfunction

  // comment body may hold any byte but an end of line
  function automatic void add_comment(ref logic [7:0] text[$]);
    int n, i;
    logic [7:0] c;
    text.push_back(CH_HASH);
    n = $urandom_range(0, 10);
    for (i = 0; i < n; i++) begin
      do c = 8'($urandom_range(0, 255));
      while (c == CH_CR || c == CH_LF);
      text.push_back(c);
    end
  endfunction

  // one line of text: mostly well formed with random content, the rest noise
  task automatic send_random_line();
    logic [7:0] text[$];
    int pick, nargs, i;
    bit eot;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      // directive: key, optional separator, arguments, optional trailing comment
      add_word(text);
      if ($urandom_range(0, 1)) text.push_back(CH_SPACE);
      case ($urandom_range(0, 2))
        0: ;
        1: text.push_back(CH_COLON);
        default: text.push_back(CH_EQUAL);
      endcase
      // every tenth directive or so reaches the argument limit or runs past it
      nargs = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 4);
      for (i = 0; i < nargs; i++) begin
        text.push_back($urandom_range(0, 3) == 0 ? CH_TAB : CH_SPACE);
        if ($urandom_range(0, 2) == 0) add_quoted(text);
        else add_word(text);
      end
      if ($urandom_range(0, 3) == 0) begin
        text.push_back(CH_SPACE);
        add_comment(text);
      end
    end else if (pick < 60) begin
      // section header
      text.push_back(CH_LBR);
      if ($urandom_range(0, 3) == 0) text.push_back(CH_SPACE);
      if ($urandom_range(0, 4) == 0) add_quoted(text);
      else if ($urandom_range(0, 9) != 0) add_word(text);
      if ($urandom_range(0, 9) != 0) text.push_back(CH_RBR);
      if ($urandom_range(0, 4) == 0) add_comment(text);
    end else if (pick < 75) begin
      add_comment(text);
    end else if (pick < 85) begin
      // blank line, gives no line summary of its own
      nargs = $urandom_range(0, 3);
      for (i = 0; i < nargs; i++) text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    end else begin
      // raw noise over the full byte range
      nargs = $urandom_range(1, 8);
      for (i = 0; i < nargs; i++) text.push_back(8'($urandom_range(0, 255)));
    end
    eot = ($urandom_range(0, 19) == 0);
    if (!eot || $urandom_range(0, 1)) begin
      case ($urandom_range(0, 3))
        0: text.push_back(CH_CR);
        1: begin
          text.push_back(CH_CR);
          text.push_back(CH_LF);
        end
        default: text.push_back(CH_LF);
      endcase
    end
    for (i = 0; i < text.size(); i++) send_char(text[i], eot && (i == text.size() - 1));
  endtask

  // receiver: stall patterns of its own, plus one long hold-off on request
  initial begin
    int stall_style, len, k;
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall_style = $urandom_range(0, 2);
        len = $urandom_range(4, 40);
        for (k = 0; k < len; k++) begin
          case (stall_style)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= (k % 3 == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // watchdog on cycles with no beat accepted on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int random_base;
    bit held, paused;
    held   = 1'b0;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: section, directive with escaped quote and a comment after
    // the arguments, escaped delimiter, unknown bytes, broken quoted string,
    // comment flushed by end of text, open line at end of text, open quote
    send_text("[s]\n", 1'b0);
    send_text("k=\"v\\\"x\"#c\r", 1'b0);
    send_text("\\:a\t", 1'b0);
    send_char(8'h01, 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("\"q", 1'b0);
    send_char(8'h80, 1'b0);
    send_text(" #x", 1'b1);
    send_text("[", 1'b1);
    send_text("]:\"z", 1'b1);

    random_base = chars_sent;
    while (chars_sent - random_base < RANDOM_CHARS) begin
      send_random_line();
      if (!held && chars_sent - random_base >= 80) begin
        // receiver holds off while the sender keeps pushing, so the queue fills
        held = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && chars_sent - random_base >= 170) begin
        // sender drains the block completely before going on
        paused = 1'b1;
        s_tvalid <= 1'b0;
        burst_left = 0;
        // let the monitor take in the last accepted character first
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (failures == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
